>>> rtl/core/u8s_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer package
// Types, byte-class constants and output packing helpers that the sanitizer
// modules share.
// ----------------------------------------------------------------------------
`default_nettype none

package u8s_pkg;

  localparam logic [7:0] CLASS_MASK = 8'hC0;
  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] LOW6_MASK  = 8'h3F;
  localparam logic [7:0] LEAD2_MIN  = 8'hC0;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD_LIMIT = 8'hF8;

  localparam logic [3:0] MAX_BYTES = 4'd8;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  typedef struct packed {
    logic [7:0]      lead;
    logic [1:0][7:0] cont;
    logic [2:0]      need;
    logic [1:0]      hc;
  } seq_state_t;

  typedef struct packed {
    logic [7:0][7:0] b;
    logic [3:0]      n;
  } obuf_t;

  function automatic obuf_t emit(input obuf_t o, input logic [7:0] x);
    obuf_t r;
    r = o;
    if (o.n < MAX_BYTES) begin
      r.b[o.n[2:0]] = x;
      r.n = 4'(o.n + 4'd1);
    end
    return r;
  endfunction

  function automatic obuf_t emit_latin1(input obuf_t o, input logic [7:0] x);
    obuf_t r;
    r = emit(o, LEAD2_MIN | {6'd0, x[7:6]});
    r = emit(r, CONT_MARK | (x & LOW6_MASK));
    return r;
  endfunction

  function automatic obuf_t flush_held(input obuf_t o, input seq_state_t s);
    obuf_t r;
    r = emit_latin1(o, s.lead);
    if (s.hc >= 2'd1) begin
      r = emit_latin1(r, s.cont[0]);
    end
    if (s.hc >= 2'd2) begin
      r = emit_latin1(r, s.cont[1]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/u8s_if.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer channels
// Valid/ready interfaces for the input byte stream and the packed results.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_end;

  modport source (output valid, output in_byte, output in_end, input ready);
  modport sink (input valid, input in_byte, input in_end, output ready);
endinterface

interface u8s_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_count;
  logic [7:0] out_b0;
  logic [7:0] out_b1;
  logic [7:0] out_b2;
  logic [7:0] out_b3;
  logic [7:0] out_b4;
  logic [7:0] out_b5;
  logic [7:0] out_b6;
  logic [7:0] out_b7;
  logic       out_end;

  modport source (
    output valid, output out_count,
    output out_b0, output out_b1, output out_b2, output out_b3,
    output out_b4, output out_b5, output out_b6, output out_b7,
    output out_end, input ready
  );
  modport sink (
    input valid, input out_count,
    input out_b0, input out_b1, input out_b2, input out_b3,
    input out_b4, input out_b5, input out_b6, input out_b7,
    input out_end, output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/utf8_sanitizer_latin1_fallback.sv
// Path: an accepted byte waits in the input register, then passes once through
// the step logic into the result register. Throughput: one byte per cycle while
// the output is not stalled; a pending result with out_ch.ready low holds both.
// Reset: synchronous, clears both valid flags and closes any open sequence.
// ----------------------------------------------------------------------------
// UTF-8 sanitizer with Latin-1 fallback
// Passes valid UTF-8 through and re-encodes stray bytes as two-byte UTF-8.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_sanitizer_latin1_fallback (
  input wire logic  clk,
  input wire logic  rst,
  u8s_in_if.sink    in_ch,
  u8s_out_if.source out_ch
);

  logic                in_valid;
  logic [7:0]          in_byte_q;
  logic                in_end_q;
  logic                out_valid;
  u8s_pkg::obuf_t      res_q;
  logic                res_end;
  logic [7:0]          held_lead;
  logic [1:0][7:0]     held_cont;
  logic [2:0]          need_len;
  logic [1:0]          held_count;
  u8s_pkg::seq_state_t cur;
  u8s_pkg::seq_state_t state_next;
  u8s_pkg::obuf_t      res_next;
  logic                adv;

  assign adv         = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || adv;

  assign cur.lead = held_lead;
  assign cur.cont = held_cont;
  assign cur.need = need_len;
  assign cur.hc   = held_count;

  u8s_step u_step (
    .cur  (cur),
    .din  (in_byte_q),
    .last (in_end_q),
    .nxt  (state_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
      held_lead  <= 8'd0;
      need_len   <= u8s_pkg::LEN_NONE;
      held_count <= 2'd0;
    end else begin
      if (in_ch.ready) begin
        in_valid <= in_ch.valid;
      end
      if (adv) begin
        out_valid  <= 1'b1;
        held_lead  <= state_next.lead;
        need_len   <= state_next.need;
        held_count <= state_next.hc;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_q <= in_ch.in_byte;
      in_end_q  <= in_ch.in_end;
    end
    if (adv) begin
      held_cont <= state_next.cont;
      res_q     <= res_next;
      res_end   <= in_end_q;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.out_count = res_q.n;
  assign out_ch.out_b0    = res_q.b[0];
  assign out_ch.out_b1    = res_q.b[1];
  assign out_ch.out_b2    = res_q.b[2];
  assign out_ch.out_b3    = res_q.b[3];
  assign out_ch.out_b4    = res_q.b[4];
  assign out_ch.out_b5    = res_q.b[5];
  assign out_ch.out_b6    = res_q.b[6];
  assign out_ch.out_b7    = res_q.b[7];
  assign out_ch.out_end   = res_end;

endmodule

`default_nettype wire

>>> rtl/core/u8s_step.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer step logic
// Decodes one byte against the open sequence and builds the packed result
// and the next sequence state.
// ----------------------------------------------------------------------------
`default_nettype none

module u8s_step (
  input  wire u8s_pkg::seq_state_t cur,
  input  wire logic [7:0]          din,
  input  wire logic                last,
  output u8s_pkg::seq_state_t      nxt,
  output u8s_pkg::obuf_t           res
);

  u8s_pkg::seq_state_t s;
  u8s_pkg::obuf_t      o;
  logic                fresh;
  logic                is_cont;

  assign is_cont = (din & u8s_pkg::CLASS_MASK) == u8s_pkg::CONT_MARK;

  always_comb begin
    o     = '0;
    s     = cur;
    fresh = 1'b0;
    if (cur.need != u8s_pkg::LEN_NONE) begin
      if (is_cont) begin
        if (3'({1'b0, cur.hc} + 3'd2) >= cur.need) begin
          o = u8s_pkg::emit(o, cur.lead);
          if (cur.hc >= 2'd1) begin
            o = u8s_pkg::emit(o, cur.cont[0]);
          end
          if (cur.hc >= 2'd2) begin
            o = u8s_pkg::emit(o, cur.cont[1]);
          end
          o      = u8s_pkg::emit(o, din);
          s.need = u8s_pkg::LEN_NONE;
          s.hc   = 2'd0;
        end else begin
          s.cont[cur.hc[0]] = din;
          s.hc              = 2'(cur.hc + 2'd1);
        end
      end else begin
        o      = u8s_pkg::flush_held(o, cur);
        s.need = u8s_pkg::LEN_NONE;
        s.hc   = 2'd0;
        fresh  = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (din < u8s_pkg::CONT_MARK) begin
        o = u8s_pkg::emit(o, din);
      end else if (din < u8s_pkg::LEAD2_MIN || din >= u8s_pkg::LEAD_LIMIT) begin
        o = u8s_pkg::emit_latin1(o, din);
      end else begin
        s.lead = din;
        s.hc   = 2'd0;
        if (din < u8s_pkg::LEAD3_MIN) begin
          s.need = u8s_pkg::LEN_TWO;
        end else if (din < u8s_pkg::LEAD4_MIN) begin
          s.need = u8s_pkg::LEN_THREE;
        end else begin
          s.need = u8s_pkg::LEN_FOUR;
        end
      end
    end

    if (last && s.need != u8s_pkg::LEN_NONE) begin
      o      = u8s_pkg::flush_held(o, s);
      s.need = u8s_pkg::LEN_NONE;
      s.hc   = 2'd0;
    end

    nxt = s;
    res = o;
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitizer testbench
// Streams directed and random byte strings into the sanitizer, predicts each
// packed result with a behavioral model of the decoder, and compares every
// result transaction field by field while both sides stall at random.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int RUN_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_byte_t;

  typedef struct packed {
    logic [3:0]      count;
    logic [7:0][7:0] bytes;
    logic            last;
  } clean_out_t;

  typedef enum logic [1:0] {UNIT_ASCII, UNIT_WHOLE, UNIT_CUT, UNIT_NOISE} unit_kind_t;

  logic clk;
  logic rst;
  int   cyc;
  int   errors;
  int   n_bytes;
  int   n_strings;
  int   n_checked;
  int   widest;
  logic in_took;
  logic steady;

  raw_byte_t  pending [$];
  clean_out_t expected_out [$];

  logic [7:0] seq_lead;
  logic [7:0] seq_cont [2];
  logic [2:0] seq_len;
  logic [1:0] seq_held;
  clean_out_t work;

  u8s_in_if  in_ch ();
  u8s_out_if out_ch ();

  utf8_sanitizer_latin1_fallback u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  function void put_byte(input logic [7:0] x);
    if (work.count < u8s_pkg::MAX_BYTES) begin
      work.bytes[work.count[2:0]] = x;
      work.count = work.count + 4'd1;
    end
  endfunction

  function void put_latin1(input logic [7:0] x);
    put_byte(u8s_pkg::LEAD2_MIN | {6'd0, x[7:6]});
    put_byte(u8s_pkg::CONT_MARK | (x & u8s_pkg::LOW6_MASK));
  endfunction

  function void drop_held();
    int k;
    put_latin1(seq_lead);
    for (k = 0; k < seq_held; k++) put_latin1(seq_cont[k]);
    seq_len = u8s_pkg::LEN_NONE;
    seq_held = 2'd0;
  endfunction

  function void take_fresh(input logic [7:0] x);
    if (x < u8s_pkg::CONT_MARK) begin
      put_byte(x);
    end else if (x < u8s_pkg::LEAD2_MIN || x >= u8s_pkg::LEAD_LIMIT) begin
      put_latin1(x);
    end else begin
      seq_lead = x;
      seq_held = 2'd0;
      if (x < u8s_pkg::LEAD3_MIN) seq_len = u8s_pkg::LEN_TWO;
      else if (x < u8s_pkg::LEAD4_MIN) seq_len = u8s_pkg::LEN_THREE;
      else seq_len = u8s_pkg::LEN_FOUR;
    end
  endfunction

  function clean_out_t sanitize(input logic [7:0] x, input logic last);
    int k;
    work = '0;
    if (seq_len != u8s_pkg::LEN_NONE) begin
      if ((x & u8s_pkg::CLASS_MASK) == u8s_pkg::CONT_MARK) begin
        if ({1'b0, seq_held} + 3'd2 >= seq_len) begin
          put_byte(seq_lead);
          for (k = 0; k < seq_held; k++) put_byte(seq_cont[k]);
          put_byte(x);
          seq_len = u8s_pkg::LEN_NONE;
          seq_held = 2'd0;
        end else begin
          seq_cont[seq_held[0]] = x;
          seq_held = seq_held + 2'd1;
        end
      end else begin
        drop_held();
        take_fresh(x);
      end
    end else begin
      take_fresh(x);
    end
    if (last && seq_len != u8s_pkg::LEN_NONE) drop_held();
    work.last = last;
    return work;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
    errors++;
  endtask

  function void add_byte(input logic [7:0] x, input logic last);
    raw_byte_t r;
    r.data = x;
    r.last = last;
    pending = {pending, r};
  endfunction

  function logic [7:0] random_lead(input int len);
    if (len == 2) return 8'($urandom_range(8'hC0, 8'hDF));
    if (len == 3) return 8'($urandom_range(8'hE0, 8'hEF));
    return 8'($urandom_range(8'hF0, 8'hF7));
  endfunction

  function logic [7:0] random_cont();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  function void fill_random();
    int         made;
    int         len;
    int         keep;
    int         k;
    int         pick;
    logic       close;
    unit_kind_t kind;
    made = 0;
    while (made < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) kind = UNIT_ASCII;
      else if (pick < 65) kind = UNIT_WHOLE;
      else if (pick < 80) kind = UNIT_CUT;
      else kind = UNIT_NOISE;
      close = ($urandom_range(0, 11) == 0);
      case (kind)
        UNIT_ASCII: begin
          add_byte(8'($urandom_range(0, 8'h7F)), close);
          made++;
        end
        UNIT_WHOLE: begin
          len = $urandom_range(2, 4);
          add_byte(random_lead(len), 1'b0);
          for (k = 1; k < len; k++) add_byte(random_cont(), close && k == len - 1);
          made += len;
        end
        UNIT_CUT: begin
          len = $urandom_range(2, 4);
          keep = $urandom_range(0, len - 2);
          add_byte(random_lead(len), close && keep == 0);
          for (k = 0; k < keep; k++) add_byte(random_cont(), close && k == keep - 1);
          made += keep + 1;
        end
        default: begin
          add_byte(8'($urandom_range(0, 255)), close);
          made++;
        end
      endcase
    end
    add_byte(8'h2E, 1'b1);
  endfunction

  function void fill_directed();
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hF8, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hC3, 1'b0);
    add_byte(8'hA9, 1'b0);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b0);
    add_byte(8'hAC, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'h9F, 1'b0);
    add_byte(8'h98, 1'b0);
    add_byte(8'h80, 1'b0);
    // A four-byte sequence broken by a leader right at the end of the string
    // produces the widest possible result.
    add_byte(8'hF4, 1'b0);
    add_byte(8'h8F, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hE0, 1'b1);
    add_byte(8'hDF, 1'b1);
    add_byte(8'hEF, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'h41, 1'b1);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  assign steady = (cyc >= 500 && cyc < 900);

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == RUN_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cyc,
               expected_out.size());
      $display("utf8_sanitizer_latin1_fallback: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin : drive_bytes
    raw_byte_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (pending.size() > 0 && (steady || $urandom_range(0, 99) >= 35)) begin
        nxt = pending.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= nxt.data;
        in_ch.in_end <= nxt.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= !rst && (steady || $urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin : watch_results
    clean_out_t want;
    clean_out_t got;
    int         i;
    in_took <= in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      want = sanitize(in_ch.in_byte, in_ch.in_end);
      expected_out = {expected_out, want};
      n_bytes++;
      if (in_ch.in_end) n_strings++;
      if (want.count > widest) widest = want.count;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.count = out_ch.out_count;
      got.bytes = {out_ch.out_b7, out_ch.out_b6, out_ch.out_b5, out_ch.out_b4,
                   out_ch.out_b3, out_ch.out_b2, out_ch.out_b1, out_ch.out_b0};
      got.last = out_ch.out_end;
      if (expected_out.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, count %0d", got.count));
      end else begin
        want = expected_out.pop_front();
        n_checked++;
        if (got.count !== want.count)
          report_mismatch($sformatf("result %0d out_count %0d, expected %0d",
                                    n_checked, got.count, want.count));
        for (i = 0; i < 8; i++) begin
          if (got.bytes[i] !== want.bytes[i])
            report_mismatch($sformatf("result %0d out_b%0d 0x%02h, expected 0x%02h",
                                      n_checked, i, got.bytes[i], want.bytes[i]));
        end
        if (got.last !== want.last)
          report_mismatch($sformatf("result %0d out_end %0b, expected %0b",
                                    n_checked, got.last, want.last));
      end
    end
  end

  initial begin
    cyc = 0;
    errors = 0;
    n_bytes = 0;
    n_strings = 0;
    n_checked = 0;
    widest = 0;
    in_took = 1'b0;
    seq_lead = 8'd0;
    seq_cont[0] = 8'd0;
    seq_cont[1] = 8'd0;
    seq_len = u8s_pkg::LEN_NONE;
    seq_held = 2'd0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'd0;
    in_ch.in_end = 1'b0;
    out_ch.ready = 1'b0;
    fill_directed();
    fill_random();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (pending.size() > 0 || in_ch.valid) @(posedge clk);
    while (expected_out.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_out.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", expected_out.size()));
    $display("Sent %0d bytes in %0d strings; checked %0d results, widest %0d bytes.",
             n_bytes, n_strings, n_checked, widest);
    if (errors == 0) begin
      $display("utf8_sanitizer_latin1_fallback: match");
    end else begin
      $display("utf8_sanitizer_latin1_fallback: mismatch");
    end
    $finish;
  end

endmodule

>>> utf8_sanitizer_latin1_fallback.f
rtl/core/u8s_pkg.sv
rtl/core/u8s_if.sv
rtl/core/u8s_step.sv
rtl/core/utf8_sanitizer_latin1_fallback.sv
tb/sv/tb_top.sv
